[design/bnts_pkg.sv]
`timescale 1ns / 1ps

package bnts_pkg;

    localparam int NOTE_COUNT_DEF   = 14;
    localparam int COUNTER_BITS_DEF = 16;
    localparam int TABLE_LEN        = 14;
    localparam int LEN_BITS         = 13;
    localparam int FREQ_BITS        = 11;
    localparam logic        MODE_TICK  = 1'b0;
    localparam logic        MODE_START = 1'b1;
    localparam logic [31:0] RELOAD_RESET = 32'h0000_FF00;

    typedef struct packed {
        logic buzzer;
        logic note_done;
        logic busy;
    } t_result;

    // note frequency in Hz
    function automatic logic [FREQ_BITS-1:0] note_freq(input logic [3:0] idx);
        logic [FREQ_BITS-1:0] f;
        case (idx)
            4'd0:    f = 11'd523;
            4'd1:    f = 11'd587;
            4'd2:    f = 11'd659;
            4'd3:    f = 11'd698;
            4'd4:    f = 11'd784;
            4'd5:    f = 11'd880;
            4'd6:    f = 11'd988;
            4'd7:    f = 11'd1047;
            4'd8:    f = 11'd1175;
            4'd9:    f = 11'd1319;
            4'd10:   f = 11'd1397;
            4'd11:   f = 11'd1568;
            4'd12:   f = 11'd1760;
            4'd13:   f = 11'd1976;
            default: f = 11'd0;
        endcase
        return f;
    endfunction

    // timer ticks per half-period: (24 MHz / 12) / (2 * freq)
    function automatic logic [10:0] half_count(input logic [3:0] idx);
        logic [10:0] h;
        case (idx)
            4'd0:    h = 11'd1912;
            4'd1:    h = 11'd1703;
            4'd2:    h = 11'd1517;
            4'd3:    h = 11'd1432;
            4'd4:    h = 11'd1275;
            4'd5:    h = 11'd1136;
            4'd6:    h = 11'd1012;
            4'd7:    h = 11'd955;
            4'd8:    h = 11'd851;
            4'd9:    h = 11'd758;
            4'd10:   h = 11'd715;
            4'd11:   h = 11'd637;
            4'd12:   h = 11'd568;
            4'd13:   h = 11'd506;
            default: h = 11'd0;
        endcase
        return h;
    endfunction

endpackage

[design/bnts_tone_core.sv]
`timescale 1ns / 1ps

module bnts_tone_core #(
    parameter int NOTE_COUNT   = bnts_pkg::NOTE_COUNT_DEF,
    parameter int COUNTER_BITS = bnts_pkg::COUNTER_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_mode,
    input  logic [3:0]        i_note_index,
    input  logic [3:0]        i_beat_quarters,
    output bnts_pkg::t_result o_res
);

    localparam int LB = bnts_pkg::LEN_BITS;
    localparam int FB = bnts_pkg::FREQ_BITS;

    logic [COUNTER_BITS-1:0] r_tick, n_tick;
    logic [COUNTER_BITS-1:0] r_reload, n_reload;
    logic                    r_buzz, n_buzz;
    logic [LB-1:0]           r_half, n_half;
    logic [LB-1:0]           r_len, n_len;
    logic [LB-1:0]           r_snd, n_snd;
    logic                    r_tone, n_tone;
    logic                    r_active, n_active;
    logic                    done;

    logic                    idx_ok;
    logic [FB-1:0]           freq;
    logic [FB+3:0]           prod;
    logic [LB-1:0]           len_new;
    logic [COUNTER_BITS-1:0] hc_ext;
    logic [LB-1:0]           half_inc;

    assign idx_ok   = (int'(i_note_index) < NOTE_COUNT) &&
                      (int'(i_note_index) < bnts_pkg::TABLE_LEN);
    assign freq     = bnts_pkg::note_freq(i_note_index);
    assign prod     = (FB+4)'(i_beat_quarters) * (FB+4)'(freq);
    assign len_new  = prod[FB+3:2];
    assign hc_ext   = COUNTER_BITS'(bnts_pkg::half_count(i_note_index));
    assign half_inc = r_half + 1'b1;

    always_comb begin
        n_tick   = r_tick;
        n_reload = r_reload;
        n_buzz   = r_buzz;
        n_half   = r_half;
        n_len    = r_len;
        n_snd    = r_snd;
        n_tone   = r_tone;
        n_active = r_active;
        done     = 1'b0;
        if (i_mode == bnts_pkg::MODE_START) begin
            if (idx_ok) begin
                n_reload = -hc_ext;
                n_tick   = -hc_ext;
                n_len    = len_new;
                n_snd    = len_new - (len_new >> 2);
                n_half   = LB'(1);
                n_tone   = 1'b1;
                n_active = 1'b1;
            end
        end else if (&r_tick) begin
            n_tick = r_reload;
            n_buzz = (r_active && r_tone) ? ~r_buzz : 1'b1;
            if (r_active) begin
                if (r_half >= r_len) begin
                    n_active = 1'b0;
                    n_half   = '0;
                    done     = 1'b1;
                end else begin
                    n_half = half_inc;
                    if (half_inc == r_snd) begin
                        n_tone = 1'b0;
                    end
                end
            end
        end else begin
            n_tick = r_tick + 1'b1;
        end
    end

    assign o_res = '{buzzer: n_buzz, note_done: done, busy: n_active};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick   <= '0;
            r_reload <= COUNTER_BITS'(bnts_pkg::RELOAD_RESET);
            r_buzz   <= 1'b1;
            r_half   <= '0;
            r_len    <= '0;
            r_snd    <= '0;
            r_tone   <= 1'b1;
            r_active <= 1'b0;
        end else if (i_en) begin
            r_tick   <= n_tick;
            r_reload <= n_reload;
            r_buzz   <= n_buzz;
            r_half   <= n_half;
            r_len    <= n_len;
            r_snd    <= n_snd;
            r_tone   <= n_tone;
            r_active <= n_active;
        end
    end

endmodule

[design/bnts_out_queue.sv]
`timescale 1ns / 1ps

// two-entry result buffer: two slots used in turn by write and read pointers
module bnts_out_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bnts_pkg::t_result i_data,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output bnts_pkg::t_result o_data
);

    bnts_pkg::t_result r_data [2];
    logic              r_wr, r_rd;
    logic [1:0]        r_count, n_count;
    logic              pop;

    assign o_valid = (r_count != 2'd0);
    assign o_space = (r_count != 2'd2);
    assign pop     = o_valid && i_ready;
    assign o_data  = r_data[r_rd];

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= n_count;
        end
    end

endmodule

[design/buzzer_note_tone_sequencer_core.sv]
`timescale 1ns / 1ps

// Buzzer tone and note-length generator.
// Input channel (i_valid / o_ready): each item is either a timer tick
// (i_mode = 0) or a note start (i_mode = 1) carrying i_note_index (0..13)
// and i_beat_quarters. A start with an index outside the table is ignored.
// Output channel (o_valid / i_ready): exactly one result item per input
// item, in order: o_buzzer level, o_note_done pulse on the tick that ends
// the note, and o_busy_res while a note plays.
// The note state updates at the accepting edge, where the result enters the
// result buffer. Throughput: one item per cycle while o_ready is high; the
// whole update is a single pass of table lookup, counter increment and compare.
// A two-entry result buffer decouples the sides: while the receiver stalls
// o_ready stays high until both entries hold results, then drops until one
// is taken. Nothing is dropped.
// Reset (synchronous, active low): counter cleared, reload 0xFF00, buzzer
// high, no note active, result buffer empty.
module buzzer_note_tone_sequencer_core #(
    parameter int NOTE_COUNT   = bnts_pkg::NOTE_COUNT_DEF,
    parameter int COUNTER_BITS = bnts_pkg::COUNTER_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_mode,
    input  logic [3:0] i_note_index,
    input  logic [3:0] i_beat_quarters,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_buzzer,
    output logic       o_note_done,
    output logic       o_busy_res
);

    logic              accept;
    bnts_pkg::t_result step_res;
    bnts_pkg::t_result out_res;

    assign accept = i_valid && o_ready;

    bnts_tone_core #(
        .NOTE_COUNT  (NOTE_COUNT),
        .COUNTER_BITS(COUNTER_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (accept),
        .i_mode         (i_mode),
        .i_note_index   (i_note_index),
        .i_beat_quarters(i_beat_quarters),
        .o_res          (step_res)
    );

    bnts_out_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (accept),
        .i_data (step_res),
        .o_space(o_ready),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (out_res)
    );

    assign o_buzzer    = out_res.buzzer;
    assign o_note_done = out_res.note_done;
    assign o_busy_res  = out_res.busy;

    a_full_has_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("result buffer full without a valid result");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("accepted item produced no result");

    a_done_ends_note: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_note_done) |-> !o_busy_res)
        else $error("note_done reported while still busy");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(out_res)))
        else $error("stalled result changed");

endmodule

[dv/tb_buzzer_note_tone_sequencer_core.sv]
`timescale 1ns / 1ps

module tb_buzzer_note_tone_sequencer_core;

    localparam int          CNT_W       = bnts_pkg::COUNTER_BITS_DEF;
    localparam int          LEN_W       = bnts_pkg::LEN_BITS;
    localparam int unsigned TIMER_HZ    = 24000000 / 12;
    localparam int unsigned PITCH_HZ [bnts_pkg::TABLE_LEN] = '{
        523, 587, 659, 698, 784, 880, 988,
        1047, 1175, 1319, 1397, 1568, 1760, 1976
    };
    localparam int STALL_LIMIT = 500;
    localparam int TAIL_CYCLES = 10;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_valid         = 1'b0;
    logic       i_mode          = bnts_pkg::MODE_TICK;
    logic [3:0] i_note_index    = 4'd0;
    logic [3:0] i_beat_quarters = 4'd0;
    logic       i_ready         = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic       o_buzzer;
    logic       o_note_done;
    logic       o_busy_res;

    // tone state as the block should hold it
    logic [CNT_W-1:0] tick_cnt;
    logic [CNT_W-1:0] reload_cnt;
    logic             buzz_q;
    logic             tone_q;
    logic             playing_q;
    logic [LEN_W-1:0] half_cnt;
    logic [LEN_W-1:0] len_q;
    logic [LEN_W-1:0] sound_q;

    bnts_pkg::t_result level_q[$];
    int      errors       = 0;
    int      quiet_cycles = 0;
    int      rx_hold      = 0;
    bit      tx_gaps      = 1'b0;
    bit      rx_gaps      = 1'b0;

    buzzer_note_tone_sequencer_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_mode          (i_mode),
        .i_note_index    (i_note_index),
        .i_beat_quarters (i_beat_quarters),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_buzzer        (o_buzzer),
        .o_note_done     (o_note_done),
        .o_busy_res      (o_busy_res)
    );

    always #6 i_clk = ~i_clk;

    function automatic void reset_tone_state();
        tick_cnt   = '0;
        reload_cnt = CNT_W'(bnts_pkg::RELOAD_RESET);
        buzz_q     = 1'b1;
        half_cnt   = '0;
        len_q      = '0;
        sound_q    = '0;
        tone_q     = 1'b1;
        playing_q  = 1'b0;
    endfunction

    function automatic bnts_pkg::t_result step_tone_state(logic mode, logic [3:0] idx,
                                                          logic [3:0] beats);
        bnts_pkg::t_result r;
        int unsigned       f;
        r.note_done = 1'b0;
        if (mode == bnts_pkg::MODE_START) begin
            // out-of-table index leaves everything as it was
            if (idx < bnts_pkg::NOTE_COUNT_DEF && idx < bnts_pkg::TABLE_LEN) begin
                f          = PITCH_HZ[idx];
                reload_cnt = CNT_W'((1 << CNT_W) - TIMER_HZ / (2 * f));
                tick_cnt   = reload_cnt;
                len_q      = LEN_W'((beats * f) >> 2);
                sound_q    = len_q - (len_q >> 2);
                half_cnt   = LEN_W'(1);
                tone_q     = 1'b1;
                playing_q  = 1'b1;
            end
        end else if (tick_cnt == '1) begin
            tick_cnt = reload_cnt;
            buzz_q   = (playing_q && tone_q) ? ~buzz_q : 1'b1;
            if (playing_q) begin
                if (half_cnt >= len_q) begin
                    playing_q   = 1'b0;
                    half_cnt    = '0;
                    r.note_done = 1'b1;
                end else begin
                    half_cnt = half_cnt + 1'b1;
                    if (half_cnt == sound_q)
                        tone_q = 1'b0;
                end
            end
        end else begin
            tick_cnt = tick_cnt + 1'b1;
        end
        r.buzzer = buzz_q;
        r.busy   = playing_q;
        return r;
    endfunction

    task automatic send_item(logic mode, logic [3:0] idx, logic [3:0] beats);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 15) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_mode          <= mode;
        i_note_index    <= idx;
        i_beat_quarters <= beats;
        do @(posedge i_clk); while (!o_ready);
        level_q.push_back(step_tone_state(mode, idx, beats));
    endtask

    // tick items carry junk in the start-only fields
    task automatic send_ticks(int n);
        repeat (n) send_item(bnts_pkg::MODE_TICK, 4'($urandom_range(0, 15)),
                             4'($urandom_range(0, 15)));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (level_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_idle_after_reset();
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        send_ticks(4);
        send_item(bnts_pkg::MODE_START, 4'd14, 4'd5);
        send_item(bnts_pkg::MODE_START, 4'd15, 4'd15);
        send_ticks(2);
    endtask

    task automatic test_every_note();
        // beats track the index so every beat bit toggles; also restarts a busy note
        for (int i = 0; i < 16; i++)
            send_item(bnts_pkg::MODE_START, 4'(i), 4'(i));
        send_ticks(3);
        wait_drained();
    endtask

    task automatic test_zero_beat_note();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        send_item(bnts_pkg::MODE_START, 4'd13, 4'd0);
        while (playing_q) send_ticks(1);
        // buzzer is left low; the next idle overflow, one half-period on, pulls it high
        send_ticks(506 + 4);
        wait_drained();
    endtask

    task automatic test_full_note();
        // a whole note runs far longer than this run; check its start and first
        // ticks, then cut it off with another start
        send_item(bnts_pkg::MODE_START, 4'd0, 4'd1);
        send_ticks(20);
        send_item(bnts_pkg::MODE_START, 4'd7, 4'd15);
        send_ticks(10);
        wait_drained();
    endtask

    task automatic test_random_notes();
        logic [3:0] idx;
        logic [3:0] beats;
        repeat (10) begin
            tx_gaps = ($urandom_range(0, 2) == 0);
            rx_gaps = ($urandom_range(0, 2) == 0);
            idx     = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, 13))
                                                  : 4'($urandom_range(0, 15));
            beats   = ($urandom_range(0, 2) == 0) ? 4'd0 : 4'($urandom_range(0, 15));
            send_item(bnts_pkg::MODE_START, idx, beats);
            if ($urandom_range(0, 1)) begin
                send_ticks($urandom_range(1, 20));
            end else begin
                repeat ($urandom_range(1, 20))
                    send_item(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                              4'($urandom_range(0, 15)));
            end
            if ($urandom_range(0, 3) == 0)
                wait_drained();
        end
    endtask

    // receiver: hold ready low for a drawn number of cycles after each result item
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            i_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_check
        bnts_pkg::t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            rx_hold <= rx_gaps ? $urandom_range(0, 15) : 0;
            if (level_q.size() == 0) begin
                $display("%0t: result item with nothing expected", $time);
                errors++;
            end else begin
                want = level_q.pop_front();
                if (o_buzzer !== want.buzzer) begin
                    $display("%0t: buzzer exp %0b got %0b", $time, want.buzzer, o_buzzer);
                    errors++;
                end
                if (o_note_done !== want.note_done) begin
                    $display("%0t: note_done exp %0b got %0b", $time, want.note_done,
                             o_note_done);
                    errors++;
                end
                if (o_busy_res !== want.busy) begin
                    $display("%0t: busy_res exp %0b got %0b", $time, want.busy, o_busy_res);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        reset_tone_state();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_idle_after_reset();
        test_every_note();
        test_zero_beat_note();
        test_full_note();
        test_random_notes();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0 && level_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
